// ===== design/esed_pkg.sv =====
package esed_pkg;

	// Frame length limit: samples beyond it are ignored until the frame closes.
	localparam int MAX_FRAME_SAMPLES = 1024;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int SQ_W     = 2 * SAMPLE_W - 1;
	localparam int ENERGY_W = 40;
	localparam int COUNT_W  = $clog2(MAX_FRAME_SAMPLES + 1);
	localparam int THR_W    = 15;
	localparam int THR_SQ_W = 2 * THR_W;
	localparam int TARGET_W = THR_SQ_W + COUNT_W;
	localparam int CMP_W    = (TARGET_W > ENERGY_W) ? TARGET_W : ENERGY_W;
	localparam int FRAME_MS_W = 8;
	localparam int TIME_W   = 16;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [THR_W-1:0]      RESET_SPEECH_THRESHOLD = THR_W'(500);
	localparam logic [FRAME_MS_W-1:0] RESET_FRAME_MS         = FRAME_MS_W'(20);
	localparam logic [TIME_W-1:0]     RESET_SILENCE_LIMIT    = TIME_W'(800);
	localparam logic [TIME_W-1:0]     RESET_NO_SPEECH_MS     = TIME_W'(5000);
	localparam logic [TIME_W-1:0]     RESET_LENGTH_LIMIT     = TIME_W'(15000);
	localparam logic [THR_SQ_W-1:0]   RESET_THRESHOLD_SQ     = THR_SQ_W'(500 * 500);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SPEECH_THRESHOLD = 3'd0,
		REG_FRAME_MS         = 3'd1,
		REG_SILENCE_LIMIT    = 3'd2,
		REG_NO_SPEECH_MS     = 3'd3,
		REG_LENGTH_LIMIT     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		REASON_NONE       = 3'd0,
		REASON_FINISH     = 3'd1,
		REASON_SILENCE    = 3'd2,
		REASON_NO_SPEECH  = 3'd3,
		REASON_MAX_LENGTH = 3'd4
	} end_reason_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
		logic                       finish_request;
	} in_item_t;

	typedef struct packed {
		logic              frame_is_speech;
		logic              speech_seen;
		logic              utterance_end;
		logic [2:0]        end_reason;
		logic [TIME_W-1:0] elapsed_ms;
	} out_item_t;

	typedef struct packed {
		logic [THR_SQ_W-1:0]   threshold_sq;
		logic [FRAME_MS_W-1:0] frame_ms;
		logic [TIME_W-1:0]     silence_limit;
		logic [TIME_W-1:0]     no_speech_limit;
		logic [TIME_W-1:0]     length_limit;
	} cfg_t;

	// Squared sample on its way to the accumulator.
	typedef struct packed {
		logic [SQ_W-1:0] sq;
		logic            frame_end;
		logic            finish;
	} sq_item_t;

	// Per-frame decision on its way to the utterance logic.
	typedef struct packed {
		logic is_speech;
		logic finish;
	} frame_dec_t;

endpackage

// ===== design/energy_speech_endpoint_detector.sv =====
// Energy-based speech endpoint detector. One signed 16-bit PCM sample is taken
// per clock cycle, without gaps, for as long as results are drained; the
// throughput is set by the frame energy accumulator, which folds in one squared
// sample each cycle. Only the sample that closes a frame gives a result item,
// which passes the input register, squarer, accumulator, energy compare, then
// the utterance timers feeding the result register. A frame is speech when its
// mean square energy reaches the threshold squared, and each frame credits
// frame_ms to the utterance timers. Configuration registers are written
// through cfg_we, cfg_index and cfg_wdata and must only be changed while no
// item is in flight.
module energy_speech_endpoint_detector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             samp_valid,
	output logic                             samp_ready,
	input  esed_pkg::in_item_t               samp,
	output logic                             res_valid,
	input  logic                             res_ready,
	output esed_pkg::out_item_t              res,
	input  logic                             cfg_we,
	input  logic [esed_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [esed_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	esed_pkg::cfg_t       cfg;
	logic                 sq_valid;
	logic                 sq_ready;
	esed_pkg::sq_item_t   sq_item;
	logic                 dec_valid;
	logic                 dec_ready;
	esed_pkg::frame_dec_t dec;

	esed_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	esed_square u_square (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_ready (samp_ready),
		.samp       (samp),
		.sq_valid   (sq_valid),
		.sq_ready   (sq_ready),
		.sq_item    (sq_item)
	);

	esed_accum u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.threshold_sq (cfg.threshold_sq),
		.sq_valid     (sq_valid),
		.sq_ready     (sq_ready),
		.sq_item      (sq_item),
		.dec_valid    (dec_valid),
		.dec_ready    (dec_ready),
		.dec          (dec)
	);

	esed_endpoint u_endpoint (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.dec_valid (dec_valid),
		.dec_ready (dec_ready),
		.dec       (dec),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

// ===== design/esed_cfg.sv =====
module esed_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [esed_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [esed_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output esed_pkg::cfg_t                       cfg
);

	localparam int THR_SQ_W = esed_pkg::THR_SQ_W;

	logic [esed_pkg::THR_W-1:0] thr_wr;
	esed_pkg::cfg_t cfg_q;

	assign thr_wr = cfg_wdata[esed_pkg::THR_W-1:0];

	// The threshold is kept squared, so the frame decision needs no multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_sq    <= esed_pkg::RESET_THRESHOLD_SQ;
			cfg_q.frame_ms        <= esed_pkg::RESET_FRAME_MS;
			cfg_q.silence_limit   <= esed_pkg::RESET_SILENCE_LIMIT;
			cfg_q.no_speech_limit <= esed_pkg::RESET_NO_SPEECH_MS;
			cfg_q.length_limit    <= esed_pkg::RESET_LENGTH_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				esed_pkg::REG_SPEECH_THRESHOLD: begin
					cfg_q.threshold_sq <= THR_SQ_W'(thr_wr) * THR_SQ_W'(thr_wr);
				end
				esed_pkg::REG_FRAME_MS: begin
					cfg_q.frame_ms <= cfg_wdata[esed_pkg::FRAME_MS_W-1:0];
				end
				esed_pkg::REG_SILENCE_LIMIT: begin
					cfg_q.silence_limit <= cfg_wdata[esed_pkg::TIME_W-1:0];
				end
				esed_pkg::REG_NO_SPEECH_MS: begin
					cfg_q.no_speech_limit <= cfg_wdata[esed_pkg::TIME_W-1:0];
				end
				esed_pkg::REG_LENGTH_LIMIT: begin
					cfg_q.length_limit <= cfg_wdata[esed_pkg::TIME_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/esed_square.sv =====
module esed_square (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 samp_valid,
	output logic                 samp_ready,
	input  esed_pkg::in_item_t   samp,
	output logic                 sq_valid,
	input  logic                 sq_ready,
	output esed_pkg::sq_item_t   sq_item
);

	localparam int PROD_W = 2 * esed_pkg::MAG_W;

	logic                       v_s1;
	esed_pkg::in_item_t         item_s1;
	logic                       v_s2;
	esed_pkg::sq_item_t         item_s2;
	logic                       en_s1;
	logic                       en_s2;
	logic [esed_pkg::MAG_W-1:0] mag;
	logic [PROD_W-1:0]          prod;

	assign en_s2 = !v_s2 || sq_ready;
	assign en_s1 = !v_s1 || en_s2;
	assign samp_ready = en_s1;

	// Magnitude of the two's complement sample; the most negative code gives 32768.
	always_comb begin
		if (item_s1.sample[esed_pkg::SAMPLE_W-1]) begin
			mag = {1'b1, {(esed_pkg::MAG_W-1){1'b0}}}
				- {1'b0, $unsigned(item_s1.sample)};
		end else begin
			mag = {1'b0, $unsigned(item_s1.sample)};
		end
		prod = PROD_W'(mag) * PROD_W'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= samp_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= samp;
		end
		if (en_s2) begin
			item_s2.sq        <= prod[esed_pkg::SQ_W-1:0];
			item_s2.frame_end <= item_s1.frame_end;
			item_s2.finish    <= item_s1.finish_request;
		end
	end

	assign sq_valid = v_s2;
	assign sq_item  = item_s2;

endmodule

// ===== design/esed_accum.sv =====
module esed_accum (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [esed_pkg::THR_SQ_W-1:0]       threshold_sq,
	input  logic                                sq_valid,
	output logic                                sq_ready,
	input  esed_pkg::sq_item_t                  sq_item,
	output logic                                dec_valid,
	input  logic                                dec_ready,
	output esed_pkg::frame_dec_t                dec
);

	localparam int ENERGY_W = esed_pkg::ENERGY_W;
	localparam int ESUM_W   = ENERGY_W + 1;
	localparam int TARGET_W = esed_pkg::TARGET_W;
	localparam int COUNT_W  = esed_pkg::COUNT_W;
	localparam int CMP_W    = esed_pkg::CMP_W;

	logic [ENERGY_W-1:0] energy_q;
	logic [TARGET_W-1:0] target_q;
	logic [COUNT_W-1:0]  count_q;
	logic [ESUM_W-1:0]   esum;
	logic [ENERGY_W-1:0] energy_nxt;
	logic [TARGET_W-1:0] target_nxt;
	logic                counting;
	logic                consume;
	logic                en_s4;

	logic                v_s3;
	logic [ENERGY_W-1:0] energy_s3;
	logic [TARGET_W-1:0] target_s3;
	logic                finish_s3;
	logic                v_s4;
	esed_pkg::frame_dec_t dec_s4;

	assign en_s4 = !v_s4 || dec_ready;

	// Samples inside a frame only feed the accumulators; the closing sample
	// also needs room in the decision stage.
	assign sq_ready = !sq_item.frame_end || !v_s3 || en_s4;
	assign consume  = sq_valid && sq_ready;
	assign counting = count_q < COUNT_W'(esed_pkg::MAX_FRAME_SAMPLES);

	// Rather than multiplying threshold squared by the count at frame end,
	// the target grows by threshold squared for every counted sample.
	always_comb begin
		esum = ESUM_W'(energy_q) + ESUM_W'(sq_item.sq);
		energy_nxt = energy_q;
		target_nxt = target_q;
		if (counting) begin
			energy_nxt = esum[ENERGY_W] ? {ENERGY_W{1'b1}} : esum[ENERGY_W-1:0];
			target_nxt = target_q + TARGET_W'(threshold_sq);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			target_q <= '0;
			count_q  <= '0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
		end else begin
			if (consume) begin
				if (sq_item.frame_end) begin
					energy_q <= '0;
					target_q <= '0;
					count_q  <= '0;
				end else begin
					energy_q <= energy_nxt;
					target_q <= target_nxt;
					if (counting) begin
						count_q <= count_q + COUNT_W'(1);
					end
				end
			end
			if (!v_s3 || en_s4) begin
				v_s3 <= consume && sq_item.frame_end;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && sq_item.frame_end) begin
			energy_s3 <= energy_nxt;
			target_s3 <= target_nxt;
			finish_s3 <= sq_item.finish;
		end
		if (en_s4) begin
			dec_s4.is_speech <= CMP_W'(energy_s3) >= CMP_W'(target_s3);
			dec_s4.finish    <= finish_s3;
		end
	end

	assign dec_valid = v_s4;
	assign dec       = dec_s4;

endmodule

// ===== design/esed_endpoint.sv =====
module esed_endpoint (
	input  logic                 clk,
	input  logic                 arst_n,
	input  esed_pkg::cfg_t       cfg,
	input  logic                 dec_valid,
	output logic                 dec_ready,
	input  esed_pkg::frame_dec_t dec,
	output logic                 res_valid,
	input  logic                 res_ready,
	output esed_pkg::out_item_t  res
);

	localparam int TIME_W = esed_pkg::TIME_W;
	localparam int TSUM_W = TIME_W + 1;

	logic                 started_q;
	logic [TIME_W-1:0]    silence_q;
	logic [TIME_W-1:0]    total_q;
	logic                 res_valid_q;
	esed_pkg::out_item_t  res_q;

	logic [TSUM_W-1:0]    total_sum;
	logic [TSUM_W-1:0]    silence_sum;
	logic [TIME_W-1:0]    total_nxt;
	logic [TIME_W-1:0]    silence_nxt;
	logic                 started_nxt;
	esed_pkg::end_reason_t reason;
	logic                 take;

	assign dec_ready = !res_valid_q || res_ready;
	assign take      = dec_valid && dec_ready;

	always_comb begin
		total_sum   = TSUM_W'(total_q) + TSUM_W'(cfg.frame_ms);
		silence_sum = TSUM_W'(silence_q) + TSUM_W'(cfg.frame_ms);
		total_nxt   = total_sum[TIME_W] ? {TIME_W{1'b1}} : total_sum[TIME_W-1:0];
		started_nxt = started_q || dec.is_speech;
		if (dec.is_speech) begin
			silence_nxt = '0;
		end else if (started_q) begin
			silence_nxt = silence_sum[TIME_W] ? {TIME_W{1'b1}} : silence_sum[TIME_W-1:0];
		end else begin
			silence_nxt = silence_q;
		end

		// Lowest code wins when several end conditions hold at once.
		if (dec.finish) begin
			reason = esed_pkg::REASON_FINISH;
		end else if (started_nxt && silence_nxt >= cfg.silence_limit) begin
			reason = esed_pkg::REASON_SILENCE;
		end else if (!started_nxt && total_nxt >= cfg.no_speech_limit) begin
			reason = esed_pkg::REASON_NO_SPEECH;
		end else if (total_nxt >= cfg.length_limit) begin
			reason = esed_pkg::REASON_MAX_LENGTH;
		end else begin
			reason = esed_pkg::REASON_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			silence_q   <= '0;
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (dec_ready) begin
				res_valid_q <= dec_valid;
			end
			if (take) begin
				// An ended utterance re-arms once its result has been formed.
				if (reason != esed_pkg::REASON_NONE) begin
					started_q <= 1'b0;
					silence_q <= '0;
					total_q   <= '0;
				end else begin
					started_q <= started_nxt;
					silence_q <= silence_nxt;
					total_q   <= total_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q.frame_is_speech <= dec.is_speech;
			res_q.speech_seen     <= started_nxt;
			res_q.utterance_end   <= reason != esed_pkg::REASON_NONE;
			res_q.end_reason      <= reason;
			res_q.elapsed_ms      <= total_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	import esed_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned RANDOM_ITEMS = 180;
	localparam int unsigned FRAMES_PER_SETTING = 4;

	typedef struct {
		in_item_t  stim;
		bit        typed;
		out_item_t want;
	} table_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       samp_valid = 1'b0;
	logic       samp_ready;
	in_item_t   samp = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	out_item_t  res;
	logic       cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = REG_SPEECH_THRESHOLD;
	logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

	// Detector settings as last written.
	logic [14:0] cf_thr = RESET_SPEECH_THRESHOLD;
	logic [7:0]  cf_frame_ms = RESET_FRAME_MS;
	logic [15:0] cf_end_sil = RESET_SILENCE_LIMIT;
	logic [15:0] cf_no_speech = RESET_NO_SPEECH_MS;
	logic [15:0] cf_max_len = RESET_LENGTH_LIMIT;

	// Running frame and utterance state of the detector.
	logic [39:0] pr_energy = '0;
	int unsigned pr_count = 0;
	bit          pr_started = 1'b0;
	logic [15:0] pr_silence = '0;
	logic [15:0] pr_total = '0;

	out_item_t   decisions_q[$];
	table_row_t  directed_rows[$];
	int unsigned items_sent = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	bit          steady = 1'b0;
	bit          hold_results = 1'b0;

	energy_speech_endpoint_detector uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.samp_valid (samp_valid),
		.samp_ready (samp_ready),
		.samp       (samp),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] add_ms(input logic [15:0] a, input logic [7:0] b);
		logic [16:0] s;
		s = 17'(a) + 17'(b);
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// Folds one sample into the frame; returns 1 with the decision when it closes one.
	function automatic bit detect_endpoint(input in_item_t it, output out_item_t r);
		logic signed [16:0] wide;
		logic [16:0]        mag;
		logic [33:0]        sq;
		logic [40:0]        acc;
		logic [40:0]        target;
		bit                 is_speech;
		end_reason_t        why;
		r = '0;
		wide = it.sample;
		mag = wide[16] ? 17'(-wide) : 17'(wide);
		if (pr_count < MAX_FRAME_SAMPLES) begin
			sq = 34'(mag) * 34'(mag);
			acc = 41'(pr_energy) + 41'(sq);
			pr_energy = acc[40] ? '1 : acc[39:0];
			pr_count++;
		end
		if (!it.frame_end)
			return 1'b0;
		target = 41'(cf_thr) * 41'(cf_thr) * 41'(pr_count);
		is_speech = {1'b0, pr_energy} >= target;
		pr_energy = '0;
		pr_count = 0;
		pr_total = add_ms(pr_total, cf_frame_ms);
		if (is_speech) begin
			pr_started = 1'b1;
			pr_silence = '0;
		end else if (pr_started) begin
			pr_silence = add_ms(pr_silence, cf_frame_ms);
		end
		if (it.finish_request)
			why = REASON_FINISH;
		else if (pr_started && pr_silence >= cf_end_sil)
			why = REASON_SILENCE;
		else if (!pr_started && pr_total >= cf_no_speech)
			why = REASON_NO_SPEECH;
		else if (pr_total >= cf_max_len)
			why = REASON_MAX_LENGTH;
		else
			why = REASON_NONE;
		r.frame_is_speech = is_speech;
		r.speech_seen = pr_started;
		r.utterance_end = (why != REASON_NONE);
		r.end_reason = why;
		r.elapsed_ms = pr_total;
		// The result keeps the values of the closing frame; the utterance then re-arms.
		if (why != REASON_NONE) begin
			pr_started = 1'b0;
			pr_silence = '0;
			pr_total = '0;
		end
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (decisions_q.size() == 0) begin
				$error("result item arrived with none expected");
				mismatch_count++;
			end else begin
				want = decisions_q.pop_front();
				check_field("frame_is_speech", want.frame_is_speech, res.frame_is_speech);
				check_field("speech_seen", want.speech_seen, res.speech_seen);
				check_field("utterance_end", want.utterance_end, res.utterance_end);
				check_field("end_reason", want.end_reason, res.end_reason);
				check_field("elapsed_ms", want.elapsed_ms, res.elapsed_ms);
			end
		end
	end

	// Result side: random back-pressure, or one long hold-off when asked for.
	initial begin : result_sink
		int unsigned held;
		forever begin
			@(negedge clk);
			if (hold_results) begin
				res_ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_results = 1'b0;
			end else begin
				res_ready <= steady || ($urandom_range(99) >= 24);
			end
		end
	end

	task automatic send_item(input in_item_t stim, input bit typed, input out_item_t want);
		out_item_t r;
		@(negedge clk);
		while (!steady && $urandom_range(99) < 24) begin
			samp_valid <= 1'b0;
			@(negedge clk);
		end
		samp <= stim;
		samp_valid <= 1'b1;
		@(posedge clk);
		while (!samp_ready)
			@(posedge clk);
		items_sent++;
		if (detect_endpoint(stim, r))
			decisions_q.push_back(typed ? want : r);
	endtask

	task automatic send_plain(input logic signed [15:0] s, input bit fe, input bit fin);
		in_item_t it;
		it.sample = s;
		it.frame_end = fe;
		it.finish_request = fin;
		send_item(it, 1'b0, '0);
	endtask

	// Waits until every decision is back and the pipeline has emptied.
	task automatic wait_idle();
		@(negedge clk);
		samp_valid <= 1'b0;
		while (decisions_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_SPEECH_THRESHOLD: cf_thr = val[14:0];
			REG_FRAME_MS:         cf_frame_ms = val[7:0];
			REG_SILENCE_LIMIT:    cf_end_sil = val;
			REG_NO_SPEECH_MS:     cf_no_speech = val;
			REG_LENGTH_LIMIT:     cf_max_len = val;
			default: ;
		endcase
	endtask

	task automatic write_setting(input int unsigned thr, input int unsigned fms,
			input int unsigned sil, input int unsigned nos, input int unsigned maxu);
		wait_idle();
		program_reg(REG_SPEECH_THRESHOLD, 16'(thr));
		program_reg(REG_FRAME_MS, 16'(fms));
		program_reg(REG_SILENCE_LIMIT, 16'(sil));
		program_reg(REG_NO_SPEECH_MS, 16'(nos));
		program_reg(REG_LENGTH_LIMIT, 16'(maxu));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Limits are mostly a few frames long so that every end reason turns up often.
	task automatic random_setting();
		int unsigned thr, fms, unit, sil, nos, maxu;
		fms = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 255);
		thr = ($urandom_range(7) == 0) ? $urandom_range(32767) : $urandom_range(20, 4000);
		unit = (fms == 0) ? 1 : fms;
		sil = unit * $urandom_range(0, 6);
		nos = unit * $urandom_range(0, 15);
		maxu = ($urandom_range(5) == 0) ? $urandom_range(65535) : unit * $urandom_range(0, 30);
		write_setting(thr, fms, sil, nos, maxu);
	endtask

	function automatic logic signed [15:0] quiet_sample();
		int unsigned amp;
		amp = $urandom_range(cf_thr);
		return $urandom_range(1) ? 16'(amp) : 16'(-amp);
	endfunction

	task automatic send_random_frame();
		in_item_t    it;
		bit          loud;
		int unsigned len;
		len = ($urandom_range(19) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 10);
		loud = 1'($urandom_range(1));
		for (int unsigned i = 0; i < len; i++) begin
			it.frame_end = (i == len - 1);
			// A stop request away from the frame end must have no effect.
			it.finish_request = it.frame_end ? ($urandom_range(99) < 6)
				: 1'($urandom_range(1));
			it.sample = loud ? 16'($urandom()) : quiet_sample();
			send_item(it, 1'b0, '0);
		end
	endtask

	task automatic add_row(input logic signed [15:0] s, input bit fe, input bit fin,
			input bit typed, input bit spch, input bit seen, input bit ue,
			input end_reason_t why, input logic [15:0] el);
		table_row_t row;
		row.stim.sample = s;
		row.stim.frame_end = fe;
		row.stim.finish_request = fin;
		row.typed = typed;
		row.want.frame_is_speech = spch;
		row.want.speech_seen = seen;
		row.want.utterance_end = ue;
		row.want.end_reason = why;
		row.want.elapsed_ms = el;
		directed_rows.push_back(row);
	endtask

	initial begin : stimulus
		int unsigned phase_end;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Reset settings: threshold 500, 20 ms frames.
		add_row(16'sd0, 1, 0, 1, 0, 0, 0, REASON_NONE, 16'd20);
		add_row(-16'sd32768, 1, 0, 1, 1, 1, 0, REASON_NONE, 16'd40);
		add_row(16'sd32767, 0, 1, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'sd0, 1, 1, 1, 1, 1, 1, REASON_FINISH, 16'd60);
		add_row(16'sd1, 0, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(-16'sd1, 1, 0, 1, 0, 0, 0, REASON_NONE, 16'd20);
		add_row(16'sd500, 1, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'sd499, 1, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(-16'sd500, 0, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'sd499, 1, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'sh5555, 0, 1, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'shAAAA, 1, 0, 0, 0, 0, 0, REASON_NONE, 16'd0);
		add_row(16'sd0, 1, 1, 1, 0, 1, 1, REASON_FINISH, 16'd120);
		add_row(16'sd32767, 1, 0, 1, 1, 1, 0, REASON_NONE, 16'd20);
		add_row(-16'sd32768, 1, 1, 1, 1, 1, 1, REASON_FINISH, 16'd40);
		foreach (directed_rows[i])
			send_item(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

		phase_end = items_sent + 100;
		while (items_sent < phase_end)
			send_random_frame();

		// Everything at zero: every frame is speech, no time is credited, every frame ends.
		write_setting(0, 0, 0, 0, 0);
		phase_end = items_sent + 40;
		while (items_sent < phase_end)
			send_random_frame();

		// Top settings with an overlong full-scale frame that saturates the energy sum.
		write_setting(32767, 255, 65535, 65535, 65535);
		steady = 1'b1;
		for (int unsigned i = 0; i < MAX_FRAME_SAMPLES + 6; i++)
			send_plain(-16'sd32768, 1'b0, 1'(i % 2));
		send_plain(-16'sd32768, 1'b1, 1'b0);
		phase_end = items_sent + 30;
		while (items_sent < phase_end)
			send_random_frame();
		steady = 1'b0;

		// One speech frame, then quiet single-sample frames until the utterance timer
		// saturates. The result side holds off meanwhile so that the block backs up.
		write_setting(1000, 254, 65535, 65535, 65535);
		hold_results = 1'b1;
		send_plain(16'sd32767, 1'b1, 1'b0);
		for (int unsigned i = 0; i < 270; i++)
			send_plain(16'($urandom_range(800)) - 16'sd400, 1'b1, 1'b0);

		phase_end = items_sent + RANDOM_ITEMS;
		while (items_sent < phase_end) begin
			random_setting();
			repeat (FRAMES_PER_SETTING) send_random_frame();
			while (decisions_q.size() == 0 && items_sent < phase_end)
				send_random_frame();
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
